// ----- rtl/core/i2cme_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types and constants for the half-bit tick sequencer and its wrapper.
// ----------------------------------------------------------------------------
package i2cme_pkg;

    // Command codes carried in the func field.
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Sequencer phase. The meaning of each step depends on the command.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_P1   = 3'd1,
        PH_P2   = 3'd2,
        PH_P3   = 3'd3,
        PH_P4   = 3'd4,
        PH_P5   = 3'd5,
        PH_P6   = 3'd6,
        PH_P7   = 3'd7
    } t_phase;

    // Sequencer state carried from tick to tick.
    typedef struct packed {
        t_op        op_kind;
        t_phase     phase;
        logic [3:0] bit_count;
        logic [7:0] shift_reg;
        logic [7:0] poll_count;
        logic       ack_choice;
        logic       scl;
        logic       sda;
        logic [7:0] rd_latch;
    } t_state;

    // Per-tick result fields.
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_data;
        logic       ack_failed;
    } t_result;

    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

endpackage : i2cme_pkg
`default_nettype wire

// ----- rtl/core/i2cme_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master byte engine tick logic
// Next-state and result logic for one half-bit tick of the line sequencer.
// ----------------------------------------------------------------------------
module i2cme_step (
    input  var i2cme_pkg::t_state  i_state,
    input  wire                    i_cmd_valid,
    input  wire [1:0]              i_func,
    input  wire [7:0]              i_wr_data,
    input  wire                    i_send_ack,
    input  wire                    i_sda_in,
    input  wire [7:0]              i_ack_timeout,
    output i2cme_pkg::t_state      o_state,
    output i2cme_pkg::t_result     o_result
);

    i2cme_pkg::t_state n_state;
    logic              done;
    logic              fail;
    logic              active;

    // Command capture, then one step of the selected sequence.
    always_comb begin
        n_state = i_state;
        done    = 1'b0;
        fail    = 1'b0;
        active  = 1'b0;

        // A command is taken only while idle.
        if (i_state.phase == i2cme_pkg::PH_IDLE && i_cmd_valid) begin
            n_state.op_kind    = i2cme_pkg::t_op'(i_func);
            n_state.phase      = i2cme_pkg::PH_P1;
            n_state.bit_count  = 4'd0;
            n_state.poll_count = 8'd0;
            n_state.ack_choice = i_send_ack;
            if (i2cme_pkg::t_op'(i_func) == i2cme_pkg::OP_WRITE) begin
                n_state.shift_reg = i_wr_data;
            end else if (i2cme_pkg::t_op'(i_func) == i2cme_pkg::OP_READ) begin
                n_state.shift_reg = 8'd0;
            end
        end

        if (n_state.phase != i2cme_pkg::PH_IDLE) begin
            active = 1'b1;
            case (n_state.op_kind)
                // Start: both high, SDA falls, SCL falls.
                i2cme_pkg::OP_START: begin
                    case (n_state.phase)
                        i2cme_pkg::PH_P1: begin
                            n_state.scl   = 1'b1;
                            n_state.sda   = 1'b1;
                            n_state.phase = i2cme_pkg::PH_P2;
                        end
                        i2cme_pkg::PH_P2: begin
                            n_state.sda   = 1'b0;
                            n_state.phase = i2cme_pkg::PH_P3;
                        end
                        i2cme_pkg::PH_P3: begin
                            n_state.scl = 1'b0;
                            done        = 1'b1;
                        end
                        default: begin
                            n_state.phase = i2cme_pkg::PH_IDLE;
                            active        = 1'b0;
                        end
                    endcase
                end
                // Stop: SDA low, SCL rises, SDA rises.
                i2cme_pkg::OP_STOP: begin
                    case (n_state.phase)
                        i2cme_pkg::PH_P1: begin
                            n_state.sda   = 1'b0;
                            n_state.phase = i2cme_pkg::PH_P2;
                        end
                        i2cme_pkg::PH_P2: begin
                            n_state.scl   = 1'b1;
                            n_state.phase = i2cme_pkg::PH_P3;
                        end
                        i2cme_pkg::PH_P3: begin
                            n_state.sda = 1'b1;
                            done        = 1'b1;
                        end
                        default: begin
                            n_state.phase = i2cme_pkg::PH_IDLE;
                            active        = 1'b0;
                        end
                    endcase
                end
                // Write: eight data bits, release SDA, poll for the ACK, stop on a timeout.
                i2cme_pkg::OP_WRITE: begin
                    case (n_state.phase)
                        i2cme_pkg::PH_P1: begin
                            n_state.scl   = 1'b0;
                            n_state.sda   = n_state.shift_reg[7];
                            n_state.phase = i2cme_pkg::PH_P2;
                        end
                        i2cme_pkg::PH_P2: begin
                            n_state.scl       = 1'b1;
                            n_state.shift_reg = {n_state.shift_reg[6:0], 1'b0};
                            n_state.bit_count = n_state.bit_count + 4'd1;
                            n_state.phase     =
                                (n_state.bit_count >= i2cme_pkg::BITS_PER_BYTE) ?
                                i2cme_pkg::PH_P3 : i2cme_pkg::PH_P1;
                        end
                        i2cme_pkg::PH_P3: begin
                            n_state.scl   = 1'b0;
                            n_state.sda   = 1'b1;
                            n_state.phase = i2cme_pkg::PH_P4;
                        end
                        i2cme_pkg::PH_P4: begin
                            n_state.scl        = 1'b1;
                            n_state.poll_count = 8'd0;
                            n_state.phase      = i2cme_pkg::PH_P5;
                        end
                        i2cme_pkg::PH_P5: begin
                            if (!i_sda_in) begin
                                n_state.scl = 1'b0;
                                done        = 1'b1;
                            end else if (n_state.poll_count >= i_ack_timeout) begin
                                n_state.sda   = 1'b0;
                                n_state.phase = i2cme_pkg::PH_P6;
                            end else begin
                                n_state.poll_count = n_state.poll_count + 8'd1;
                            end
                        end
                        i2cme_pkg::PH_P6: begin
                            n_state.scl   = 1'b1;
                            n_state.phase = i2cme_pkg::PH_P7;
                        end
                        // Last step of the timeout stop; the SCL low after it is dropped.
                        default: begin
                            n_state.sda = 1'b1;
                            done        = 1'b1;
                            fail        = 1'b1;
                        end
                    endcase
                end
                // Read: eight sampled bits, then the ACK or NACK answer.
                default: begin
                    case (n_state.phase)
                        i2cme_pkg::PH_P1: begin
                            n_state.scl   = 1'b1;
                            n_state.sda   = 1'b1;
                            n_state.phase = i2cme_pkg::PH_P2;
                        end
                        i2cme_pkg::PH_P2: begin
                            n_state.shift_reg = {n_state.shift_reg[6:0], i_sda_in};
                            n_state.scl       = 1'b0;
                            n_state.bit_count = n_state.bit_count + 4'd1;
                            if (n_state.bit_count >= i2cme_pkg::BITS_PER_BYTE) begin
                                n_state.rd_latch = n_state.shift_reg;
                                n_state.phase    = i2cme_pkg::PH_P3;
                            end else begin
                                n_state.phase = i2cme_pkg::PH_P1;
                            end
                        end
                        i2cme_pkg::PH_P3: begin
                            n_state.sda   = ~n_state.ack_choice;
                            n_state.phase = i2cme_pkg::PH_P4;
                        end
                        i2cme_pkg::PH_P4: begin
                            n_state.scl   = 1'b1;
                            n_state.phase = i2cme_pkg::PH_P5;
                        end
                        i2cme_pkg::PH_P5: begin
                            n_state.scl = 1'b0;
                            if (n_state.ack_choice) begin
                                n_state.phase = i2cme_pkg::PH_P6;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        i2cme_pkg::PH_P6: begin
                            n_state.sda = 1'b1;
                            done        = 1'b1;
                        end
                        default: begin
                            n_state.phase = i2cme_pkg::PH_IDLE;
                            active        = 1'b0;
                        end
                    endcase
                end
            endcase

            if (done) begin
                n_state.phase = i2cme_pkg::PH_IDLE;
            end
        end
    end

    // Result fields follow the updated state.
    assign o_state             = n_state;
    assign o_result.scl_level  = n_state.scl;
    assign o_result.sda_level  = n_state.sda;
    assign o_result.busy_res   = active & ~done;
    assign o_result.done_res   = done;
    assign o_result.rd_data    = n_state.rd_latch;
    assign o_result.ack_failed = fail;

endmodule : i2cme_step
`default_nettype wire

// ----- rtl/core/i2c_master_byte_engine.sv -----
// A result is registered at the edge that accepts its tick; one tick per cycle
// unless the result channel stalls. Sequencer state and the result register
// both update at the accepting edge, so ticks may follow back to back.
// Input ready stays high while the result register is empty or being taken.
// Reset (synchronous, active low) idles the sequencer, releases both lines,
// clears the read byte and loads the acknowledge timeout with 250.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master byte engine
// Half-bit tick line sequencer with a registered result stage.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // Tick input channel.
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire        i_cmd_valid,
    input  wire [1:0]  i_func,
    input  wire [7:0]  i_wr_data,
    input  wire        i_send_ack,
    input  wire        i_sda_in,
    // Result channel.
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rd_data,
    output logic       o_ack_failed,
    // Configuration write port.
    input  wire        i_cfg_wr_en,
    input  wire [7:0]  i_cfg_wr_data
);

    i2cme_pkg::t_state  r_state;
    i2cme_pkg::t_state  n_state;
    i2cme_pkg::t_result n_result;
    i2cme_pkg::t_result r_result;
    logic               r_out_valid;
    logic [7:0]         r_ack_timeout;
    logic               in_fire;

    // Accept a tick whenever the result register can take its answer.
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign in_fire    = i_in_valid & o_in_ready;

    i2cme_step u_step (
        .i_state       (r_state),
        .i_cmd_valid   (i_cmd_valid),
        .i_func        (i_func),
        .i_wr_data     (i_wr_data),
        .i_send_ack    (i_send_ack),
        .i_sda_in      (i_sda_in),
        .i_ack_timeout (r_ack_timeout),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.op_kind    <= i2cme_pkg::OP_START;
            r_state.phase      <= i2cme_pkg::PH_IDLE;
            r_state.bit_count  <= 4'd0;
            r_state.shift_reg  <= 8'd0;
            r_state.poll_count <= 8'd0;
            r_state.ack_choice <= 1'b0;
            r_state.scl        <= 1'b1;
            r_state.sda        <= 1'b1;
            r_state.rd_latch   <= 8'd0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Acknowledge timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= i2cme_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg_wr_en) begin
            r_ack_timeout <= i_cfg_wr_data;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl_level  = r_result.scl_level;
    assign o_sda_level  = r_result.sda_level;
    assign o_busy_res   = r_result.busy_res;
    assign o_done_res   = r_result.done_res;
    assign o_rd_data    = r_result.rd_data;
    assign o_ack_failed = r_result.ack_failed;

endmodule : i2c_master_byte_engine
`default_nettype wire

// ----- rtl/core/i2cme_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master byte engine checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cme_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_in_ready,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input wire       o_scl_level,
    input wire       o_sda_level,
    input wire       o_busy_res,
    input wire       o_done_res,
    input wire [7:0] o_rd_data,
    input wire       o_ack_failed
);

    // A sequence is never busy and done on the same tick.
    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_busy_res && o_done_res))
        else $error("busy and done both set");

    // A failed acknowledge ends the write sequence.
    a_fail_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ack_failed) |-> o_done_res)
        else $error("ack failure without done");

    // After the timeout stop both lines are released.
    a_fail_lines_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ack_failed) |-> (o_scl_level && o_sda_level))
        else $error("lines not released after ack failure");

    // A stalled result holds its read byte and done flag.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_rd_data) && $stable(o_done_res)))
        else $error("stalled result changed");

    // An empty result register always takes a new tick.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule : i2cme_checker

bind i2c_master_byte_engine i2cme_checker u_i2cme_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_scl_level  (o_scl_level),
    .o_sda_level  (o_sda_level),
    .o_busy_res   (o_busy_res),
    .o_done_res   (o_done_res),
    .o_rd_data    (o_rd_data),
    .o_ack_failed (o_ack_failed)
);
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Drives half-bit tick transactions into the engine and predicts the SCL and
// SDA drive levels, busy, done, read byte and acknowledge failure of every
// tick. Each result transaction is checked against the oldest prediction.
// Directed tests cover idle ticks, start, stop, writes, reads, ignored commands
// and acknowledge timeouts at the timeout extremes. Random traffic of bus
// transactions follows, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TRAFFIC_TICKS = 600;
    localparam int MAX_PRINTS = 100;

    // Clock and reset.
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;

    // Tick channel.
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic             i_cmd_valid = 1'b0;
    i2cme_pkg::t_op   i_func = i2cme_pkg::OP_START;
    logic [7:0]       i_wr_data = 8'h00;
    logic             i_send_ack = 1'b0;
    logic             i_sda_in = 1'b1;

    // Result channel.
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_scl_level;
    logic       o_sda_level;
    logic       o_busy_res;
    logic       o_done_res;
    logic [7:0] o_rd_data;
    logic       o_ack_failed;

    // Configuration port.
    logic       i_cfg_wr_en = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;

    // Predicted line sequencer state.
    i2cme_pkg::t_op    op = i2cme_pkg::OP_START;
    i2cme_pkg::t_phase ph = i2cme_pkg::PH_IDLE;
    logic [3:0]        bits = 4'd0;
    logic [7:0]        shreg = 8'd0;
    logic [7:0]        polls = 8'd0;
    logic              ackc = 1'b0;
    logic              scl = 1'b1;
    logic              sda = 1'b1;
    logic [7:0]        rd_byte = 8'd0;
    logic [7:0]        tmo = i2cme_pkg::ACK_TIMEOUT_RST;

    i2cme_pkg::t_result expected_ticks[$];
    int         fail_count = 0;
    int         cycle_count = 0;
    int         seq_ticks = 0;
    int         hold_off_len = 0;
    bit         no_idle = 1'b0;

    i2c_master_byte_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd_valid   (i_cmd_valid),
        .i_func        (i_func),
        .i_wr_data     (i_wr_data),
        .i_send_ack    (i_send_ack),
        .i_sda_in      (i_sda_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_scl_level   (o_scl_level),
        .o_sda_level   (o_sda_level),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_rd_data     (o_rd_data),
        .o_ack_failed  (o_ack_failed),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    endtask

    // Random gap length: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 98)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic pick_sda(input int hi_pct);
        return ($urandom_range(99) < hi_pct) ? 1'b1 : 1'b0;
    endfunction

    // Advances the predicted sequencer by one tick and queues its result.
    task automatic predict_tick(input logic cmdv, input i2cme_pkg::t_op f,
                                input logic [7:0] wd, input logic sack,
                                input logic sdain);
        i2cme_pkg::t_result r;
        logic    done;
        logic    fail;
        logic    active;
        done = 1'b0;
        fail = 1'b0;
        active = 1'b0;
        // A command is taken only while idle.
        if (ph == i2cme_pkg::PH_IDLE && cmdv) begin
            op = f;
            ph = i2cme_pkg::PH_P1;
            bits = 4'd0;
            polls = 8'd0;
            ackc = sack;
            if (f == i2cme_pkg::OP_WRITE)
                shreg = wd;
            else if (f == i2cme_pkg::OP_READ)
                shreg = 8'd0;
        end
        if (ph != i2cme_pkg::PH_IDLE) begin
            active = 1'b1;
            case (op)
                i2cme_pkg::OP_START: begin
                    case (ph)
                        i2cme_pkg::PH_P1: begin
                            scl = 1'b1; sda = 1'b1; ph = i2cme_pkg::PH_P2;
                        end
                        i2cme_pkg::PH_P2: begin sda = 1'b0; ph = i2cme_pkg::PH_P3; end
                        i2cme_pkg::PH_P3: begin scl = 1'b0; done = 1'b1; end
                        default: begin ph = i2cme_pkg::PH_IDLE; active = 1'b0; end
                    endcase
                end
                i2cme_pkg::OP_STOP: begin
                    case (ph)
                        i2cme_pkg::PH_P1: begin sda = 1'b0; ph = i2cme_pkg::PH_P2; end
                        i2cme_pkg::PH_P2: begin scl = 1'b1; ph = i2cme_pkg::PH_P3; end
                        i2cme_pkg::PH_P3: begin sda = 1'b1; done = 1'b1; end
                        default: begin ph = i2cme_pkg::PH_IDLE; active = 1'b0; end
                    endcase
                end
                i2cme_pkg::OP_WRITE: begin
                    case (ph)
                        i2cme_pkg::PH_P1: begin
                            scl = 1'b0; sda = shreg[7]; ph = i2cme_pkg::PH_P2;
                        end
                        i2cme_pkg::PH_P2: begin
                            scl = 1'b1;
                            shreg = {shreg[6:0], 1'b0};
                            bits = bits + 4'd1;
                            ph = (bits >= i2cme_pkg::BITS_PER_BYTE) ?
                                 i2cme_pkg::PH_P3 : i2cme_pkg::PH_P1;
                        end
                        i2cme_pkg::PH_P3: begin
                            scl = 1'b0; sda = 1'b1; ph = i2cme_pkg::PH_P4;
                        end
                        i2cme_pkg::PH_P4: begin
                            scl = 1'b1; polls = 8'd0; ph = i2cme_pkg::PH_P5;
                        end
                        // Acknowledge poll: a low SDA ends the write, too many
                        // high polls start the recovery stop.
                        i2cme_pkg::PH_P5: begin
                            if (!sdain) begin
                                scl = 1'b0;
                                done = 1'b1;
                            end else if (polls >= tmo) begin
                                sda = 1'b0;
                                ph = i2cme_pkg::PH_P6;
                            end else begin
                                polls = polls + 8'd1;
                            end
                        end
                        i2cme_pkg::PH_P6: begin scl = 1'b1; ph = i2cme_pkg::PH_P7; end
                        default: begin sda = 1'b1; done = 1'b1; fail = 1'b1; end
                    endcase
                end
                default: begin
                    case (ph)
                        i2cme_pkg::PH_P1: begin
                            scl = 1'b1; sda = 1'b1; ph = i2cme_pkg::PH_P2;
                        end
                        i2cme_pkg::PH_P2: begin
                            shreg = {shreg[6:0], sdain};
                            scl = 1'b0;
                            bits = bits + 4'd1;
                            if (bits >= i2cme_pkg::BITS_PER_BYTE) begin
                                rd_byte = shreg;
                                ph = i2cme_pkg::PH_P3;
                            end else begin
                                ph = i2cme_pkg::PH_P1;
                            end
                        end
                        i2cme_pkg::PH_P3: begin
                            sda = ackc ? 1'b0 : 1'b1; ph = i2cme_pkg::PH_P4;
                        end
                        i2cme_pkg::PH_P4: begin scl = 1'b1; ph = i2cme_pkg::PH_P5; end
                        i2cme_pkg::PH_P5: begin
                            scl = 1'b0;
                            if (ackc)
                                ph = i2cme_pkg::PH_P6;
                            else
                                done = 1'b1;
                        end
                        i2cme_pkg::PH_P6: begin sda = 1'b1; done = 1'b1; end
                        default: begin ph = i2cme_pkg::PH_IDLE; active = 1'b0; end
                    endcase
                end
            endcase
            if (done)
                ph = i2cme_pkg::PH_IDLE;
        end
        r.scl_level = scl;
        r.sda_level = sda;
        r.busy_res = active && !done;
        r.done_res = done;
        r.rd_data = rd_byte;
        r.ack_failed = fail;
        expected_ticks.push_back(r);
    endtask

    // Offers one tick transaction after a random gap and waits for acceptance.
    task automatic send_tick(input logic cmdv, input i2cme_pkg::t_op f,
                             input logic [7:0] wd, input logic sack,
                             input logic sdain);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd_valid <= cmdv;
        i_func <= f;
        i_wr_data <= wd;
        i_send_ack <= sack;
        i_sda_in <= sdain;
        do @(posedge i_clk); while (!o_in_ready);
        predict_tick(cmdv, f, wd, sack, sdain);
    endtask

    // Issues one command and feeds ticks until the sequence completes. While
    // busy, noise_pct of the ticks offer a stray command that must be ignored.
    task automatic run_cmd(input i2cme_pkg::t_op f, input logic [7:0] wd,
                           input logic sack, input int hi_pct, input int noise_pct);
        logic cmdv;
        send_tick(1'b1, f, wd, sack, pick_sda(hi_pct));
        seq_ticks++;
        while (ph != i2cme_pkg::PH_IDLE) begin
            cmdv = ($urandom_range(99) < noise_pct) ? 1'b1 : 1'b0;
            send_tick(cmdv, i2cme_pkg::t_op'($urandom_range(3)), 8'($urandom),
                      1'($urandom), pick_sda(hi_pct));
            seq_ticks++;
        end
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Writes the acknowledge timeout while the engine is idle.
    task automatic write_timeout(input logic [7:0] value);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tmo = value;
    endtask

    // Compares each result transaction with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        i2cme_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_ticks.size() == 0) begin
                report_mismatch("result with no prediction", 0, 0);
            end else begin
                want = expected_ticks.pop_front();
                if (o_scl_level !== want.scl_level)
                    report_mismatch("scl_level", o_scl_level, want.scl_level);
                if (o_sda_level !== want.sda_level)
                    report_mismatch("sda_level", o_sda_level, want.sda_level);
                if (o_busy_res !== want.busy_res)
                    report_mismatch("busy_res", o_busy_res, want.busy_res);
                if (o_done_res !== want.done_res)
                    report_mismatch("done_res", o_done_res, want.done_res);
                if (o_rd_data !== want.rd_data)
                    report_mismatch("rd_data", o_rd_data, want.rd_data);
                if (o_ack_failed !== want.ack_failed)
                    report_mismatch("ack_failed", o_ack_failed, want.ack_failed);
            end
        end
    end

    // Result receiver: random stalls, plus long hold-offs on request.
    initial begin : out_ready_driver
        int n;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_len > 0) begin
                n = hold_off_len;
                hold_off_len = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(99) < 25) begin
                n = pick_gap();
                if (n == 0)
                    n = 1;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Idle ticks with the payload at its extremes; the lines must hold.
    task automatic test_idle_ticks();
        send_tick(1'b0, i2cme_pkg::OP_READ, 8'hFF, 1'b1, 1'b0);
        send_tick(1'b0, i2cme_pkg::OP_START, 8'h00, 1'b0, 1'b1);
        send_tick(1'b0, i2cme_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_start_stop();
        run_cmd(i2cme_pkg::OP_START, 8'h00, 1'b0, 50, 0);
        run_cmd(i2cme_pkg::OP_STOP, 8'hFF, 1'b1, 50, 0);
    endtask

    // Writes of the extreme bytes and 8'hA5, the last with stray commands while busy.
    task automatic test_write_bytes();
        run_cmd(i2cme_pkg::OP_START, 8'h00, 1'b0, 50, 0);
        run_cmd(i2cme_pkg::OP_WRITE, 8'h00, 1'b0, 0, 0);
        run_cmd(i2cme_pkg::OP_WRITE, 8'hFF, 1'b1, 50, 0);
        run_cmd(i2cme_pkg::OP_WRITE, 8'hA5, 1'b0, 30, 100);
        run_cmd(i2cme_pkg::OP_STOP, 8'h00, 1'b0, 50, 0);
    endtask

    // Reads right after a start, so SDA is still pulled low when the first
    // read bit releases it; ACK and NACK answers.
    task automatic test_read_bytes();
        run_cmd(i2cme_pkg::OP_START, 8'h00, 1'b0, 50, 0);
        run_cmd(i2cme_pkg::OP_READ, 8'h00, 1'b1, 100, 0);
        run_cmd(i2cme_pkg::OP_READ, 8'hFF, 1'b0, 0, 0);
        run_cmd(i2cme_pkg::OP_READ, 8'h3C, 1'b1, 50, 100);
        run_cmd(i2cme_pkg::OP_STOP, 8'h00, 1'b0, 50, 0);
    endtask

    // No ACK with timeout zero, one and maximum; a last write may see an ACK.
    task automatic test_ack_timeout();
        write_timeout(8'd0);
        run_cmd(i2cme_pkg::OP_WRITE, 8'h5A, 1'b0, 100, 0);
        write_timeout(8'd255);
        run_cmd(i2cme_pkg::OP_WRITE, 8'hC3, 1'b1, 100, 0);
        write_timeout(8'd1);
        run_cmd(i2cme_pkg::OP_WRITE, 8'h81, 1'b0, 100, 0);
        run_cmd(i2cme_pkg::OP_WRITE, 8'h7E, 1'b0, 50, 0);
    endtask

    // Long receiver hold-off while the sender keeps offering ticks.
    task automatic test_backpressure();
        drain();
        no_idle = 1'b1;
        hold_off_len = 80;
        run_cmd(i2cme_pkg::OP_WRITE, 8'h96, 1'b1, 0, 20);
        run_cmd(i2cme_pkg::OP_READ, 8'h00, 1'b1, 50, 0);
        no_idle = 1'b0;
    endtask

    // Random bus transactions with random content, plus single commands,
    // idle noise and occasional timeout changes.
    task automatic test_random_traffic();
        int r;
        int n;
        int hi;
        while (seq_ticks < TRAFFIC_TICKS) begin
            if ($urandom_range(9) == 0)
                no_idle = !no_idle;
            hi = (tmo <= 8'd8) ? (($urandom_range(2) == 0) ? 100 : 50)
                               : (($urandom_range(1) == 0) ? 0 : 80);
            r = $urandom_range(99);
            if (r < 8) begin
                write_timeout(($urandom_range(2) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(3)));
            end else if (r < 75) begin
                run_cmd(i2cme_pkg::OP_START, 8'($urandom), 1'($urandom), 50, 10);
                run_cmd(i2cme_pkg::OP_WRITE, 8'($urandom), 1'($urandom), hi, 10);
                n = $urandom_range(3, 1);
                repeat (n) begin
                    if ($urandom_range(1) == 0)
                        run_cmd(i2cme_pkg::OP_WRITE, 8'($urandom), 1'($urandom), hi, 10);
                    else
                        run_cmd(i2cme_pkg::OP_READ, 8'($urandom), 1'($urandom), 50, 10);
                end
                // Sometimes leave the bus for a repeated start.
                if ($urandom_range(4) != 0)
                    run_cmd(i2cme_pkg::OP_STOP, 8'($urandom), 1'($urandom), 50, 10);
            end else if (r < 90) begin
                run_cmd(i2cme_pkg::t_op'($urandom_range(3)), 8'($urandom), 1'($urandom),
                        hi, 30);
            end else begin
                n = $urandom_range(4, 1);
                repeat (n)
                    send_tick(1'b0, i2cme_pkg::t_op'($urandom_range(3)), 8'($urandom),
                              1'($urandom), 1'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    // Test sequence.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_ticks();
        test_start_stop();
        test_write_bytes();
        test_read_bytes();
        test_ack_timeout();
        test_backpressure();
        write_timeout(i2cme_pkg::ACK_TIMEOUT_RST);
        test_random_traffic();
        drain();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
